/* hdl/sbii_pkg.sv */
// Shared types and constants for the strided block index iterator.
// Holds the request/response word layouts, command codes and register indexes.
// No dependencies.
package sbii_pkg;

   localparam int MAX_AXES_DEF = 7;

   localparam int CMD_W   = 2;
   localparam int AXIS_W  = 3;
   localparam int COORD_W = 32;
   localparam int SPAN_W  = 31;
   localparam int RANK_W  = 3;

   // command codes; the fourth code is ignored
   localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RESTART = 2'd1;
   localparam logic [CMD_W-1:0] CMD_NEXT    = 2'd2;

   // register index, taken from address bit 2
   localparam logic REG_RANK      = 1'b0;
   localparam logic REG_USE_STEPS = 1'b1;

   typedef struct packed {
      logic [CMD_W-1:0]          cmd;
      logic [AXIS_W-1:0]         axis;
      logic signed [COORD_W-1:0] lower;
      logic [SPAN_W-1:0]         span;
      logic [SPAN_W-1:0]         stride;
   } req_type;

   typedef struct packed {
      logic [AXIS_W-1:0]         out_axis;
      logic signed [COORD_W-1:0] coordinate;
      logic                      last;
      logic                      done_res;
   } rsp_type;

   // broadcast from the sequencer to every axis cell
   typedef struct packed {
      logic              load;
      logic              restart;
      logic              go;
      logic              shift;
      logic              use_steps;
      logic              any_room;
      logic [RANK_W-1:0] rank;
   } cell_ctrl_type;

endpackage

/* hdl/strided_block_index_iterator.sv */
// Top level of the strided block index iterator: sequencer, config registers
// and the chain of sbii_axis_cell instances. Uses sbii_pkg.
//
//   channel | direction | handshake              | word
//   req     | in        | req_valid / req_ready  | sbii_pkg::req_type
//   rsp     | out       | rsp_valid / rsp_ready  | sbii_pkg::rsp_type
//   csr     | in/out    | psel/penable, pready=1 | rank @0x0, use_steps @0x4
//
// A next word with n axes in use gives n result words, one per cycle unless
// rsp_ready stalls, as the coordinates shift down the cell chain; the request
// port is busy until they are out, and a finished walk gives one done word.
// The next request word is taken once the last result is in the output
// register. Reset clears rank and step mode and marks the walk finished; axis
// bounds hold garbage until loaded. A stalled rsp_ready holds the chain.
module strided_block_index_iterator #(
   parameter int MAX_AXES = sbii_pkg::MAX_AXES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sbii_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sbii_pkg::rsp_type rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   localparam int CNT_W = $clog2(MAX_AXES + 1);
   localparam int IDX_W = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;

   logic [sbii_pkg::RANK_W-1:0] rank_ff, rank_in;
   logic                        use_steps_ff, use_steps_in;
   logic                        finished_ff, finished_in;
   logic [CNT_W-1:0]            rem_ff, rem_in;
   logic [IDX_W-1:0]            idx_ff, idx_in;
   logic                        done_pend_ff, done_pend_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   sbii_pkg::rsp_type           rsp_data_ff, rsp_data_in;

   sbii_pkg::cell_ctrl_type ctrl;
   logic                         inner_chain [MAX_AXES:0];
   logic [sbii_pkg::COORD_W-1:0] emit_chain  [MAX_AXES:0];

   logic             accept;
   logic             is_next;
   logic             walk;
   logic             done_req;
   logic             out_free;
   logic             emit;
   logic             csr_write;
   logic [CNT_W-1:0] n_active;

   assign req_ready  = (rem_ff == '0) && !done_pend_ff;
   assign accept     = req_valid && req_ready;
   assign n_active   = (int'(rank_ff) > MAX_AXES) ? CNT_W'(MAX_AXES) : CNT_W'(rank_ff);
   assign is_next    = accept && (req_data.cmd == sbii_pkg::CMD_NEXT);
   assign walk       = is_next && !finished_ff && (n_active != '0);
   assign done_req   = is_next && !walk;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign emit       = (rem_ff != '0) && out_free;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   always_comb begin
      ctrl.load      = accept && (req_data.cmd == sbii_pkg::CMD_LOAD);
      ctrl.restart   = accept && (req_data.cmd == sbii_pkg::CMD_RESTART);
      ctrl.go        = walk;
      ctrl.shift     = emit;
      ctrl.use_steps = use_steps_ff;
      ctrl.any_room  = inner_chain[0];
      ctrl.rank      = rank_ff;
   end

   assign inner_chain[MAX_AXES] = 1'b0;
   assign emit_chain[MAX_AXES]  = '0;

   for (genvar i = 0; i < MAX_AXES; i++) begin : g_cell
      sbii_axis_cell #(
         .AXIS_ID(i)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .req         (req_data),
         .inner_in    (inner_chain[i+1]),
         .inner_out   (inner_chain[i]),
         .emit_next_in(emit_chain[i+1]),
         .emit_out    (emit_chain[i])
      );
   end

   always_comb begin
      rank_in      = rank_ff;
      use_steps_in = use_steps_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            sbii_pkg::REG_RANK:      rank_in      = csr_pwdata[sbii_pkg::RANK_W-1:0];
            sbii_pkg::REG_USE_STEPS: use_steps_in = csr_pwdata[0];
            default:                 rank_in      = rank_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         sbii_pkg::REG_RANK:      csr_prdata = {{(32 - sbii_pkg::RANK_W){1'b0}}, rank_ff};
         sbii_pkg::REG_USE_STEPS: csr_prdata = {31'b0, use_steps_ff};
         default:                 csr_prdata = '0;
      endcase
   end

   always_comb begin
      finished_in = finished_ff;
      if (ctrl.restart) begin
         finished_in = 1'b0;
      end else if (done_req) begin
         finished_in = 1'b1;
      end else if (walk) begin
         finished_in = !inner_chain[0];
      end

      rem_in = rem_ff;
      idx_in = idx_ff;
      if (walk) begin
         rem_in = n_active;
         idx_in = '0;
      end else if (emit) begin
         rem_in = rem_ff - CNT_W'(1);
         idx_in = idx_ff + IDX_W'(1);
      end

      done_pend_in = done_pend_ff;
      if (done_req) begin
         done_pend_in = 1'b1;
      end else if (done_pend_ff && out_free) begin
         done_pend_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done_pend_ff && out_free) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.out_axis   = '0;
         rsp_data_in.coordinate = '0;
         rsp_data_in.last       = 1'b1;
         rsp_data_in.done_res   = 1'b1;
      end else if (emit) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.out_axis   = sbii_pkg::AXIS_W'(idx_ff);
         rsp_data_in.coordinate = emit_chain[0];
         rsp_data_in.last       = (rem_ff == CNT_W'(1));
         rsp_data_in.done_res   = 1'b0;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff      <= '0;
         use_steps_ff <= 1'b0;
         finished_ff  <= 1'b1;
         rem_ff       <= '0;
         idx_ff       <= '0;
         done_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rank_ff      <= rank_in;
         use_steps_ff <= use_steps_in;
         finished_ff  <= finished_in;
         rem_ff       <= rem_in;
         idx_ff       <= idx_in;
         done_pend_ff <= done_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

/* hdl/sbii_axis_cell.sv */
// One axis cell of the iterator chain: start/current bounds, stride, room
// detection and one stage of the coordinate shift line. Uses sbii_pkg.
module sbii_axis_cell #(
   parameter int AXIS_ID = 0
) (
   input  logic                          clock,
   input  sbii_pkg::cell_ctrl_type       ctrl,
   input  sbii_pkg::req_type             req,
   input  logic                          inner_in,
   output logic                          inner_out,
   input  logic [sbii_pkg::COORD_W-1:0]  emit_next_in,
   output logic [sbii_pkg::COORD_W-1:0]  emit_out
);

   logic [sbii_pkg::COORD_W-1:0] start_lower_ff, start_lower_in;
   logic [sbii_pkg::SPAN_W-1:0]  start_span_ff, start_span_in;
   logic [sbii_pkg::SPAN_W-1:0]  stride_ff, stride_in;
   logic [sbii_pkg::COORD_W-1:0] cur_lower_ff, cur_lower_in;
   logic [sbii_pkg::SPAN_W-1:0]  cur_span_ff, cur_span_in;
   logic [sbii_pkg::COORD_W-1:0] emit_ff, emit_in;

   logic [sbii_pkg::SPAN_W-1:0] step;
   logic active;
   logic hit;
   logic room;
   logic adv;
   logic rewind;

   assign step   = ctrl.use_steps ? stride_ff : sbii_pkg::SPAN_W'(1);
   assign active = int'(ctrl.rank) > AXIS_ID;
   assign hit    = int'(req.axis) == AXIS_ID;
   assign room   = active && (cur_span_ff > step);

   // innermost axis with room advances; active axes inside it rewind
   assign inner_out = inner_in || room;
   assign adv       = room && !inner_in;
   assign rewind    = active && !inner_out && ctrl.any_room;

   assign emit_out = emit_ff;

   always_comb begin
      start_lower_in = start_lower_ff;
      start_span_in  = start_span_ff;
      stride_in      = stride_ff;
      cur_lower_in   = cur_lower_ff;
      cur_span_in    = cur_span_ff;
      emit_in        = emit_ff;
      if (ctrl.load && hit) begin
         start_lower_in = req.lower;
         start_span_in  = req.span;
         stride_in      = req.stride;
         cur_lower_in   = req.lower;
         cur_span_in    = req.span;
      end else if (ctrl.restart) begin
         cur_lower_in = start_lower_ff;
         cur_span_in  = start_span_ff;
      end else if (ctrl.go) begin
         // snapshot the coordinate before it moves
         emit_in = cur_lower_ff;
         if (adv) begin
            cur_lower_in = cur_lower_ff + sbii_pkg::COORD_W'(step);
            cur_span_in  = cur_span_ff - step;
         end else if (rewind) begin
            cur_lower_in = start_lower_ff;
            cur_span_in  = start_span_ff;
         end
      end else if (ctrl.shift) begin
         emit_in = emit_next_in;
      end
   end

   always_ff @(posedge clock) begin
      start_lower_ff <= start_lower_in;
      start_span_ff  <= start_span_in;
      stride_ff      <= stride_in;
      cur_lower_ff   <= cur_lower_in;
      cur_span_ff    <= cur_span_in;
      emit_ff        <= emit_in;
   end

endmodule

/* hdl/sbii_checker.sv */
// Port-level checks for strided_block_index_iterator, attached with bind.
// Uses sbii_pkg.
module sbii_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input sbii_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input sbii_pkg::rsp_type rsp_data
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // a done word is a lone, empty, final word
   a_done_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |->
         rsp_data.last && (rsp_data.coordinate == 0) && (rsp_data.out_axis == 3'd0))
      else $error("malformed done word");

   // a next request blocks the request port while its results drain
   a_next_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.cmd == sbii_pkg::CMD_NEXT) |=> !req_ready)
      else $error("request taken while results still pending");

   // results of one walk step come back to back in axis order
   a_axis_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last |=>
         rsp_valid && !rsp_data.done_res &&
         (rsp_data.out_axis == $past(rsp_data.out_axis) + 3'd1))
      else $error("result words out of axis order");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind strided_block_index_iterator sbii_checker u_sbii_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .req_data (req_data),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data (rsp_data)
);

/* test/testbench.sv */
// Self-checking bench for strided_block_index_iterator: directed table, then random walks.
// Predicts coordinate words from its own copy of the axis bounds and walk state.
// Depends on sbii_pkg and the strided_block_index_iterator RTL.
`timescale 1ns / 100ps

module testbench;

   localparam int MAXA = sbii_pkg::MAX_AXES_DEF;
   localparam logic [sbii_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD = 300;

   typedef enum logic {ROW_WORD, ROW_REG} row_kind_type;

   typedef struct {
      row_kind_type      kind;
      logic              reg_idx;
      logic [31:0]       reg_val;
      sbii_pkg::req_type word;
      bit                typed;
      sbii_pkg::rsp_type want;
   } table_row_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   sbii_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   sbii_pkg::rsp_type rsp_data;
   logic    csr_psel;
   logic    csr_penable;
   logic    csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // walk state as the block should hold it
   logic [31:0] seed_lower [MAXA];
   logic [30:0] seed_span [MAXA];
   logic [30:0] step_len [MAXA];
   logic [31:0] cur_lower [MAXA];
   logic [30:0] cur_span [MAXA];
   logic        walk_done;
   logic [2:0]  cfg_rank;
   logic        cfg_use_steps;

   sbii_pkg::rsp_type coords_due[$];
   int      failures;
   int      cycle_count;
   bit      steady;
   bit      long_hold;
   bit      typed_now;
   sbii_pkg::rsp_type typed_want;

   strided_block_index_iterator DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return 0;
      if (r < 9) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   function automatic sbii_pkg::req_type load_word(logic [2:0] axis);
      sbii_pkg::req_type w;
      logic [31:0]       raw;
      int                r;
      w.cmd = sbii_pkg::CMD_LOAD;
      w.axis = axis;
      w.lower = $urandom;
      raw = $urandom;
      w.span = ($urandom_range(0, 7) < 6) ? 31'($urandom_range(0, 3)) : raw[30:0];
      raw = $urandom;
      r = $urandom_range(0, 9);
      if (r < 6) w.stride = 31'($urandom_range(1, 3));
      else if (r < 8) w.stride = '0;
      else w.stride = raw[30:0];
      return w;
   endfunction

   function automatic sbii_pkg::req_type noise_word();
      sbii_pkg::req_type w;
      logic [31:0]       raw;
      w.cmd = 2'($urandom_range(0, 3));
      w.axis = 3'($urandom_range(0, 7));
      w.lower = $urandom;
      raw = $urandom;
      w.span = raw[30:0];
      raw = $urandom;
      w.stride = raw[30:0];
      return w;
   endfunction

   function automatic sbii_pkg::req_type cmd_word(logic [sbii_pkg::CMD_W-1:0] cmd);
      sbii_pkg::req_type w;
      w = noise_word();
      w.cmd = cmd;
      return w;
   endfunction

   function automatic table_row_type word_row(logic [1:0] cmd, logic [2:0] axis,
                                              logic [31:0] lower, logic [30:0] span,
                                              logic [30:0] stride);
      table_row_type row;
      row.kind = ROW_WORD;
      row.reg_idx = sbii_pkg::REG_RANK;
      row.reg_val = '0;
      row.word.cmd = cmd;
      row.word.axis = axis;
      row.word.lower = lower;
      row.word.span = span;
      row.word.stride = stride;
      row.typed = 1'b0;
      row.want = '0;
      return row;
   endfunction

   function automatic table_row_type typed_next(logic [2:0] axis, logic [31:0] coord,
                                                logic last, logic done);
      table_row_type row;
      row = word_row(sbii_pkg::CMD_NEXT, '0, '0, '0, '0);
      row.typed = 1'b1;
      row.want.out_axis = axis;
      row.want.coordinate = coord;
      row.want.last = last;
      row.want.done_res = done;
      return row;
   endfunction

   function automatic table_row_type reg_row(logic idx, logic [31:0] val);
      table_row_type row;
      row = word_row(CMD_UNUSED, '0, '0, '0, '0);
      row.kind = ROW_REG;
      row.reg_idx = idx;
      row.reg_val = val;
      return row;
   endfunction

   // Apply one accepted word to the walk state and queue the coordinates it yields.
   task automatic walk_model(input sbii_pkg::req_type w);
      int                n;
      int                k;
      int                i;
      logic [30:0]       step;
      sbii_pkg::rsp_type r;
      n = (cfg_rank > MAXA) ? MAXA : cfg_rank;
      case (w.cmd)
         sbii_pkg::CMD_LOAD: begin
            if (w.axis < MAXA) begin
               seed_lower[w.axis] = w.lower;
               seed_span[w.axis] = w.span;
               step_len[w.axis] = w.stride;
               cur_lower[w.axis] = w.lower;
               cur_span[w.axis] = w.span;
            end
         end
         sbii_pkg::CMD_RESTART: begin
            for (i = 0; i < MAXA; i++) begin
               cur_lower[i] = seed_lower[i];
               cur_span[i] = seed_span[i];
            end
            walk_done = 1'b0;
         end
         sbii_pkg::CMD_NEXT: begin
            if (walk_done || n == 0) begin
               walk_done = 1'b1;
               r.out_axis = '0;
               r.coordinate = '0;
               r.last = 1'b1;
               r.done_res = 1'b1;
               coords_due.push_back(r);
            end else begin
               for (i = 0; i < n; i++) begin
                  r.out_axis = 3'(i);
                  r.coordinate = cur_lower[i];
                  r.last = (i == n - 1);
                  r.done_res = 1'b0;
                  coords_due.push_back(r);
               end
               // find the innermost axis with room left
               k = -1;
               for (i = n - 1; i >= 0 && k < 0; i--) begin
                  step = cfg_use_steps ? step_len[i] : 31'd1;
                  if (cur_span[i] > step) k = i;
               end
               if (k < 0) begin
                  walk_done = 1'b1;
               end else begin
                  step = cfg_use_steps ? step_len[k] : 31'd1;
                  cur_lower[k] = cur_lower[k] + {1'b0, step};
                  cur_span[k] = cur_span[k] - step;
                  for (i = k + 1; i < n; i++) begin
                     cur_lower[i] = seed_lower[i];
                     cur_span[i] = seed_span[i];
                  end
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic send_word(input sbii_pkg::req_type w, input bit typed,
                            input sbii_pkg::rsp_type want);
      int gap;
      gap = steady ? 0 : pick_gap();
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      typed_now = typed;
      typed_want = want;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid, wait for every queued result, then let the block go quiet.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (coords_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_register(input logic idx, input logic [31:0] val);
      logic [31:0] readback;
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx == sbii_pkg::REG_RANK) cfg_rank = val[2:0];
      else cfg_use_steps = val[0];
      // read it back
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      if (readback !== val) begin
         failures++;
         if (failures <= 10)
            $display("register %0d readback: expected %h, got %h", idx, val, readback);
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Predict on each accepted request word, check each accepted result word.
   always @(posedge clock) begin
      int                depth;
      sbii_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            depth = coords_due.size();
            walk_model(req_data);
            if (typed_now) begin
               while (coords_due.size() > depth) void'(coords_due.pop_back());
               coords_due.push_back(typed_want);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (coords_due.size() == 0) begin
               failures++;
               if (failures <= 10) $display("result word with none expected: %p", rsp_data);
            end else begin
               want = coords_due.pop_front();
               if (rsp_data.out_axis !== want.out_axis
                   || rsp_data.coordinate !== want.coordinate
                   || rsp_data.last !== want.last
                   || rsp_data.done_res !== want.done_res) begin
                  failures++;
                  if (failures <= 10)
                     $display("exp/act axis %0d/%0d coord %h/%h last %b/%b done %b/%b",
                              want.out_axis, rsp_data.out_axis,
                              want.coordinate, rsp_data.coordinate,
                              want.last, rsp_data.last,
                              want.done_res, rsp_data.done_res);
               end
            end
         end
      end
   end

   // Result side: short random stalls, plus one long hold-off on request.
   initial begin
      int hold_left;
      int stall_left;
      rsp_ready = 1'b0;
      hold_left = 0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (long_hold) begin
            rsp_ready <= 1'b0;
            hold_left = LONG_HOLD - 1;
            long_hold = 1'b0;
         end else if (steady) begin
            rsp_ready <= 1'b1;
         end else if (stall_left != 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 2) == 0) stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      table_row_type     plan[$];
      sbii_pkg::req_type w;
      sbii_pkg::rsp_type no_want;
      int         phase;
      int         phase_words;
      int         axes;
      int         a;
      int         i;
      bit         ignored;

      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      steady = 1'b0;
      long_hold = 1'b0;
      typed_now = 1'b0;
      typed_want = '0;
      no_want = '0;
      failures = 0;
      cycle_count = 0;
      walk_done = 1'b1;
      cfg_rank = '0;
      cfg_use_steps = 1'b0;
      for (i = 0; i < MAXA; i++) begin
         seed_lower[i] = '0;
         seed_span[i] = '0;
         step_len[i] = '0;
         cur_lower[i] = '0;
         cur_span[i] = '0;
      end

      // finished after reset; load every axis before anything can walk them
      plan.push_back(typed_next(3'd0, 32'd0, 1'b1, 1'b1));
      plan.push_back(word_row(sbii_pkg::CMD_LOAD, 3'd0, 32'h8000_0000, 31'd2, 31'd1));
      plan.push_back(word_row(sbii_pkg::CMD_LOAD, 3'd1, 32'h7FFF_FFFF, 31'd3, 31'd1));
      plan.push_back(word_row(sbii_pkg::CMD_LOAD, 3'd2, 32'd0, 31'd0, 31'h7FFF_FFFF));
      plan.push_back(word_row(sbii_pkg::CMD_LOAD, 3'd3, -32'sd5, 31'd1, 31'd2));
      plan.push_back(word_row(sbii_pkg::CMD_LOAD, 3'd4, 32'd100, 31'h7FFF_FFFF,
                              31'h7FFF_FFFF));
      plan.push_back(word_row(sbii_pkg::CMD_LOAD, 3'd5, 32'd7, 31'd4, 31'd0));
      plan.push_back(word_row(sbii_pkg::CMD_LOAD, 3'd6, 32'hFFFF_FFFF, 31'd5, 31'd2));
      plan.push_back(word_row(sbii_pkg::CMD_LOAD, 3'd7, 32'h1234_5678, 31'd9, 31'd3));
      plan.push_back(typed_next(3'd0, 32'd0, 1'b1, 1'b1));
      plan.push_back(word_row(sbii_pkg::CMD_RESTART, 3'd0, 32'd0, 31'd0, 31'd0));
      plan.push_back(typed_next(3'd0, 32'd0, 1'b1, 1'b1));
      plan.push_back(reg_row(sbii_pkg::REG_RANK, 32'd1));
      plan.push_back(word_row(sbii_pkg::CMD_RESTART, 3'd0, 32'd0, 31'd0, 31'd0));
      plan.push_back(typed_next(3'd0, 32'h8000_0000, 1'b1, 1'b0));
      plan.push_back(word_row(sbii_pkg::CMD_NEXT, 3'd0, 32'd0, 31'd0, 31'd0));
      plan.push_back(word_row(sbii_pkg::CMD_NEXT, 3'd0, 32'd0, 31'd0, 31'd0));
      plan.push_back(reg_row(sbii_pkg::REG_RANK, 32'd2));
      plan.push_back(word_row(sbii_pkg::CMD_RESTART, 3'd0, 32'd0, 31'd0, 31'd0));
      for (i = 0; i < 4; i++)
         plan.push_back(word_row(sbii_pkg::CMD_NEXT, 3'd0, 32'd0, 31'd0, 31'd0));
      plan.push_back(word_row(CMD_UNUSED, 3'd7, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF));
      plan.push_back(reg_row(sbii_pkg::REG_RANK, 32'd7));
      plan.push_back(reg_row(sbii_pkg::REG_USE_STEPS, 32'd1));
      plan.push_back(word_row(sbii_pkg::CMD_RESTART, 3'd0, 32'd0, 31'd0, 31'd0));
      for (i = 0; i < 4; i++)
         plan.push_back(word_row(sbii_pkg::CMD_NEXT, 3'd0, 32'd0, 31'd0, 31'd0));

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[r]) begin
         if (plan[r].kind == ROW_REG) begin
            settle();
            set_register(plan[r].reg_idx, plan[r].reg_val);
         end else begin
            send_word(plan[r].word, plan[r].typed, plan[r].want);
         end
      end

      for (phase = 0; phase < 6; phase++) begin
         settle();
         steady = (phase == 3);
         if (phase == 2) long_hold = 1'b1;
         set_register(sbii_pkg::REG_RANK, (phase == 0) ? 32'd7 : (phase == 1) ? 32'd0
                      : 32'($urandom_range(0, 7)));
         set_register(sbii_pkg::REG_USE_STEPS, (phase == 0) ? 32'd1 : (phase == 1) ? 32'd0
                      : 32'($urandom_range(0, 1)));
         phase_words = 0;
         while (phase_words < 16) begin
            if ($urandom_range(0, 4) != 0) begin
               // well-formed walk: load the axes in use, restart, step through
               axes = (cfg_rank == 0) ? $urandom_range(1, MAXA) : cfg_rank;
               for (a = 0; a < axes; a++) begin
                  send_word(load_word(3'(a)), 1'b0, no_want);
                  phase_words++;
               end
               send_word(cmd_word(sbii_pkg::CMD_RESTART), 1'b0, no_want);
               phase_words++;
               repeat ($urandom_range(1, 12)) begin
                  send_word(cmd_word(sbii_pkg::CMD_NEXT), 1'b0, no_want);
                  phase_words++;
               end
            end else begin
               repeat ($urandom_range(1, 3)) begin
                  w = noise_word();
                  ignored = (w.cmd == CMD_UNUSED)
                            || (w.cmd == sbii_pkg::CMD_LOAD && w.axis >= MAXA);
                  send_word(w, 1'b0, no_want);
                  if (!ignored) phase_words++;
               end
            end
         end
      end

      steady = 1'b0;
      settle();
      if (coords_due.size() != 0) begin
         failures++;
         $display("%0d expected result words never arrived", coords_due.size());
      end
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
